[src/sfde_pkg.sv]
// types, codes and constants shared by the site fst / dxy estimator
package sfde_pkg;

  localparam int unsigned CntW       = 11;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POP1_HAP = 2'd0,
    CFG_POP2_HAP = 2'd1,
    CFG_MIN_MAF  = 2'd2,
    CFG_DXY_MODE = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    KIND_DROP = 2'd0,
    KIND_DXY  = 2'd1,
    KIND_FST  = 2'd2
  } site_kind_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_G1,
    BK_G2,
    BK_PI1,
    BK_PI2,
    BK_DMUL,
    BK_DXY,
    BK_TMUL,
    BK_T1,
    BK_T2,
    BK_NMUL,
    BK_ACC,
    BK_STAT,
    BK_WF,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [CntW-1:0] alt_count_pop1;
    logic [CntW-1:0] alt_count_pop2;
    logic            major_is_alt;
  } in_item_t;

  typedef struct packed {
    logic               site_kept;
    logic signed [31:0] site_stat;
    logic [16:0]        pi_pop1;
    logic [16:0]        pi_pop2;
    logic [16:0]        freq_pop1;
    logic [16:0]        freq_pop2;
    logic signed [31:0] weighted_fst;
  } out_item_t;

  // classified site handed from the front to the back
  typedef struct packed {
    site_kind_e      kind;
    logic [CntW-1:0] n1;
    logic [CntW-1:0] n2;
    logic [CntW-1:0] c1;
    logic [CntW-1:0] c2;
    logic [CntW-1:0] m1;
    logic [CntW-1:0] m2;
  } site_rec_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [47:0] divisor;
    logic [6:0]  iters;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

[src/site_fst_dxy_estimator_unit.sv]
// top level of the per-site hudson fst / dxy estimator
//
// sites enter on in_valid_i / in_ready_o with in_item_i, results leave on
// out_valid_o / out_ready_i with out_item_o, one result per site, in order.
// registers (haplotype counts, minor frequency threshold, mode) are written
// through cfg_valid_i / cfg_index_i / cfg_data_i; cfg_ready_o is always high.
// the front classifies a site in the transfer cycle and queues it (two deep);
// the back works through it with one shared radix-2 divider, one divide
// at a time; a dropped site needs only the weighted fst divide, and none
// while the fst sums are zero.
// the result sits in an output register, so the back may start the next site
// while it waits; a stalled receiver holds that register and, once the back
// and the queue fill, in_ready_o drops.
// reset clears the fst sums, the queue and the registers to their defaults.
module site_fst_dxy_estimator_unit #(
  parameter int MAX_HAPLOTYPES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sfde_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sfde_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sfde_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sfde_pkg::CfgDataW-1:0] cfg_data_i
);
  import sfde_pkg::*;

  logic [CntW-1:0]     pop1_hap_q, pop2_hap_q;
  logic [CfgDataW-1:0] min_maf_q;
  logic                dxy_mode_q;

  logic      push, pop, full, empty;
  site_rec_t rec_in, rec_out;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop1_hap_q <= CntW'(2);
      pop2_hap_q <= CntW'(2);
      min_maf_q  <= '0;
      dxy_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_POP1_HAP: pop1_hap_q <= cfg_data_i[CntW-1:0];
        CFG_POP2_HAP: pop2_hap_q <= cfg_data_i[CntW-1:0];
        CFG_MIN_MAF:  min_maf_q  <= cfg_data_i;
        CFG_DXY_MODE: dxy_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sfde_front #(
    .MAX_HAPLOTYPES(MAX_HAPLOTYPES)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .pop1_hap_i (pop1_hap_q),
    .pop2_hap_i (pop2_hap_q),
    .min_maf_i  (min_maf_q),
    .dxy_mode_i (dxy_mode_q),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (rec_in)
  );

  sfde_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (full),
    .pop_i   (pop),
    .rec_o   (rec_out),
    .empty_o (empty)
  );

  sfde_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sfde_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .rec_i       (rec_out),
    .pop_o       (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // a dropped site carries no statistic, no pi and no frequencies
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.site_kept |->
      out_item_o.site_stat == 32'sd0 && out_item_o.pi_pop1 == '0 &&
      out_item_o.pi_pop2 == '0 && out_item_o.freq_pop1 == '0 &&
      out_item_o.freq_pop2 == '0)
    else $error("dropped site with non-zero fields");

  // pi is only reported in dxy mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !dxy_mode_q |-> out_item_o.pi_pop1 == '0 && out_item_o.pi_pop2 == '0)
    else $error("pi reported in fst mode");

  // corrected frequencies never exceed one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.freq_pop1 <= 17'd65536 && out_item_o.freq_pop2 <= 17'd65536)
    else $error("frequency above one");

  // the queue is never pushed while full nor popped while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full) && !(pop && empty))
    else $error("queue overrun or underrun");

endmodule

[src/sfde_front.sv]
// front end: takes a site, clamps counts, applies the frequency filter and classifies it
module sfde_front #(
  parameter int MAX_HAPLOTYPES = 1024
) (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sfde_pkg::in_item_t            in_item_i,
  input  logic [sfde_pkg::CntW-1:0]     pop1_hap_i,
  input  logic [sfde_pkg::CntW-1:0]     pop2_hap_i,
  input  logic [sfde_pkg::CfgDataW-1:0] min_maf_i,
  input  logic                          dxy_mode_i,
  input  logic                          full_i,
  output logic                          push_o,
  output sfde_pkg::site_rec_t           rec_o
);
  import sfde_pkg::*;

  localparam int NClip = (MAX_HAPLOTYPES > 2047) ? 2047 : MAX_HAPLOTYPES;
  localparam logic [CntW-1:0] NMax = NClip[CntW-1:0];

  logic [CntW-1:0] n1, n2, a1, a2;
  logic [CntW:0]   s, big_n, minor;
  logic [27:0]     lhs, rhs;
  logic            pass;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    n1 = (pop1_hap_i > NMax) ? NMax : pop1_hap_i;
    n2 = (pop2_hap_i > NMax) ? NMax : pop2_hap_i;
    a1 = (in_item_i.alt_count_pop1 > n1) ? n1 : in_item_i.alt_count_pop1;
    a2 = (in_item_i.alt_count_pop2 > n2) ? n2 : in_item_i.alt_count_pop2;
    s     = {1'b0, a1} + {1'b0, a2};
    big_n = {1'b0, n1} + {1'b0, n2};
    minor = ({s, 1'b0} > {1'b0, big_n}) ? big_n - s : s;
    lhs   = {minor, 16'd0};
    rhs   = 28'(min_maf_i) * 28'(big_n);
    pass  = (n1 != '0) && (n2 != '0) && (lhs >= rhs);

    rec_o.n1 = n1;
    rec_o.n2 = n2;
    rec_o.c1 = in_item_i.major_is_alt ? n1 - a1 : a1;
    rec_o.c2 = in_item_i.major_is_alt ? n2 - a2 : a2;
    rec_o.m1 = ({a1, 1'b0} > {1'b0, n1}) ? n1 - a1 : a1;
    rec_o.m2 = ({a2, 1'b0} > {1'b0, n2}) ? n2 - a2 : a2;
    if (!pass) begin
      rec_o.kind = KIND_DROP;
    end else if (dxy_mode_i) begin
      rec_o.kind = KIND_DXY;
    end else if (n1 < CntW'(2) || n2 < CntW'(2)) begin
      rec_o.kind = KIND_DROP;
    end else begin
      rec_o.kind = KIND_FST;
    end
  end

endmodule

[src/sfde_queue.sv]
// short fifo between front and back
module sfde_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sfde_pkg::site_rec_t rec_i,
  output logic                full_o,
  input  logic                pop_i,
  output sfde_pkg::site_rec_t rec_o,
  output logic                empty_o
);
  import sfde_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  site_rec_t       mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o  = (count_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign rec_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[src/sfde_divider.sv]
// shared radix-2 restoring divider, one quotient bit per cycle
module sfde_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfde_pkg::div_req_t req_i,
  output sfde_pkg::div_rsp_t rsp_o
);
  import sfde_pkg::*;

  logic        busy_q;
  logic [6:0]  cnt_q;
  logic [47:0] rem_q, divisor_q;
  logic [63:0] dvd_q;
  logic [48:0] trial, diff;
  logic        ge;

  assign trial = {rem_q, dvd_q[63]};
  assign ge    = trial >= {1'b0, divisor_q};
  assign diff  = trial - {1'b0, divisor_q};

  assign rsp_o.done     = busy_q && (cnt_q == '0);
  assign rsp_o.quotient = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.iters;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  // dividend is pre-shifted so only the useful bits are iterated
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
      dvd_q     <= req_i.dividend << (7'd64 - req_i.iters);
    end else if (busy_q && cnt_q != '0) begin
      rem_q <= ge ? diff[47:0] : trial[47:0];
      dvd_q <= {dvd_q[62:0], ge};
    end
  end

endmodule

[src/sfde_back.sv]
// back end: sequences the per-site arithmetic, keeps the fst sums and holds the result
module sfde_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  sfde_pkg::site_rec_t rec_i,
  output logic                pop_o,
  output sfde_pkg::div_req_t  div_req_o,
  input  sfde_pkg::div_rsp_t  div_rsp_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sfde_pkg::out_item_t out_item_o
);
  import sfde_pkg::*;

  function automatic logic [31:0] sat_q16(input logic neg, input logic [63:0] q);
    logic big;
    big = |q[63:31];
    if (!neg) begin
      sat_q16 = big ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      sat_q16 = big ? 32'h8000_0000 : 32'd0 - q[31:0];
    end
  endfunction

  back_state_e state_q, state_d;
  logic        issued_q, issued_d;
  logic        load_out;

  site_rec_t   rec_q;
  logic [16:0] g1_q, g2_q, pi1_q, pi2_q;
  logic [21:0] pa_q, pb_q, nn_q;
  logic [31:0] v1_q, v2_q;
  logic [30:0] t1_q, t2_q;
  logic [32:0] dsq_q, e1_q, e2_q;
  logic [34:0] num_q;
  logic [33:0] den_q;
  logic [31:0] stat_q, wf_q;
  logic        kept_q;
  logic [47:0] numsum_q, densum_q;
  logic        out_valid_q;
  out_item_t   out_item_q;

  logic [33:0]        v1_w, v2_w, e1_w, e2_w;
  logic signed [17:0] d_w;
  logic signed [35:0] dsq_w;
  logic [34:0]        num_w, magn_w;
  logic [33:0]        den_w;
  logic [48:0]        nsum_w, dsum_w, magw_w;
  logic [22:0]        dn_w;

  assign v1_w   = 34'(g1_q) * 34'(17'd65536 - g1_q);
  assign v2_w   = 34'(g2_q) * 34'(17'd65536 - g2_q);
  assign e1_w   = 34'(g1_q) * 34'(17'd65536 - g2_q);
  assign e2_w   = 34'(g2_q) * 34'(17'd65536 - g1_q);
  assign d_w    = $signed({1'b0, g1_q}) - $signed({1'b0, g2_q});
  assign dsq_w  = d_w * d_w;
  assign num_w  = {2'b00, dsq_q} - {4'b0000, t1_q} - {4'b0000, t2_q};
  assign den_w  = {1'b0, e1_q} + {1'b0, e2_q};
  assign nsum_w = {numsum_q[47], numsum_q} + {{14{num_w[34]}}, num_w};
  assign dsum_w = {1'b0, densum_q} + {15'd0, den_w};
  assign magn_w = num_q[34] ? 35'd0 - num_q : num_q;
  assign magw_w = numsum_q[47] ? 49'd0 - {1'b1, numsum_q} : {1'b0, numsum_q};
  assign dn_w   = {1'b0, pa_q} + {1'b0, pb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  always_comb begin
    logic div_state;
    state_d   = state_q;
    issued_d  = issued_q;
    pop_o     = 1'b0;
    load_out  = 1'b0;
    div_req_o = '0;
    div_state = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = (rec_i.kind == KIND_DROP) ? BK_WF : BK_G1;
        end
      end
      BK_G1: begin
        div_state           = 1'b1;
        div_req_o.dividend  = 64'({rec_q.c1, 16'd0});
        div_req_o.divisor   = 48'(rec_q.n1);
        div_req_o.iters     = 7'd32;
      end
      BK_G2: begin
        div_state           = 1'b1;
        div_req_o.dividend  = 64'({rec_q.c2, 16'd0});
        div_req_o.divisor   = 48'(rec_q.n2);
        div_req_o.iters     = 7'd32;
      end
      BK_PI1: begin
        div_state           = 1'b1;
        div_req_o.dividend  = 64'({rec_q.m1, 17'd0});
        div_req_o.divisor   = 48'({1'b0, rec_q.n1} + 12'd1);
        div_req_o.iters     = 7'd32;
      end
      BK_PI2: begin
        div_state           = 1'b1;
        div_req_o.dividend  = 64'({rec_q.m2, 17'd0});
        div_req_o.divisor   = 48'({1'b0, rec_q.n2} + 12'd1);
        div_req_o.iters     = 7'd32;
      end
      BK_DMUL: state_d = BK_DXY;
      BK_DXY: begin
        div_state           = 1'b1;
        div_req_o.dividend  = 64'({dn_w, 16'd0});
        div_req_o.divisor   = 48'(nn_q);
        div_req_o.iters     = 7'd40;
      end
      BK_TMUL: state_d = BK_T1;
      BK_T1: begin
        div_state           = 1'b1;
        div_req_o.dividend  = 64'(v1_q);
        div_req_o.divisor   = 48'(rec_q.n1 - 11'd1);
        div_req_o.iters     = 7'd32;
      end
      BK_T2: begin
        div_state           = 1'b1;
        div_req_o.dividend  = 64'(v2_q);
        div_req_o.divisor   = 48'(rec_q.n2 - 11'd1);
        div_req_o.iters     = 7'd32;
      end
      BK_NMUL: state_d = BK_ACC;
      BK_ACC:  state_d = BK_STAT;
      BK_STAT: begin
        if (den_q == '0) begin
          state_d = BK_WF;
        end else begin
          div_state           = 1'b1;
          div_req_o.dividend  = 64'({magn_w, 16'd0});
          div_req_o.divisor   = 48'(den_q);
          div_req_o.iters     = 7'd64;
        end
      end
      BK_WF: begin
        if (densum_q == '0) begin
          state_d = BK_DONE;
        end else begin
          div_state           = 1'b1;
          div_req_o.dividend  = {magw_w[47:0], 16'd0};
          div_req_o.divisor   = densum_q;
          div_req_o.iters     = 7'd64;
        end
      end
      BK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase

    // each divide state issues once, then waits for the quotient
    if (div_state) begin
      if (!issued_q) begin
        div_req_o.start = 1'b1;
        issued_d        = 1'b1;
      end else if (div_rsp_i.done) begin
        issued_d = 1'b0;
        unique case (state_q)
          BK_G1:   state_d = BK_G2;
          BK_G2:   state_d = (rec_q.kind == KIND_DXY) ? BK_PI1 : BK_TMUL;
          BK_PI1:  state_d = BK_PI2;
          BK_PI2:  state_d = BK_DMUL;
          BK_DXY:  state_d = BK_WF;
          BK_T1:   state_d = BK_T2;
          BK_T2:   state_d = BK_NMUL;
          BK_STAT: state_d = BK_WF;
          BK_WF:   state_d = BK_DONE;
          default: state_d = BK_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        rec_q  <= rec_i;
        kept_q <= 1'b0;
        stat_q <= '0;
      end
      BK_G1:  if (div_rsp_i.done) g1_q <= div_rsp_i.quotient[16:0];
      BK_G2:  if (div_rsp_i.done) g2_q <= div_rsp_i.quotient[16:0];
      BK_PI1: if (div_rsp_i.done) pi1_q <= div_rsp_i.quotient[16:0];
      BK_PI2: if (div_rsp_i.done) pi2_q <= div_rsp_i.quotient[16:0];
      BK_DMUL: begin
        pa_q <= 22'(rec_q.c1) * 22'(rec_q.n2 - rec_q.c2);
        pb_q <= 22'(rec_q.c2) * 22'(rec_q.n1 - rec_q.c1);
        nn_q <= 22'(rec_q.n1) * 22'(rec_q.n2);
      end
      BK_DXY: begin
        if (div_rsp_i.done) begin
          stat_q <= div_rsp_i.quotient[31:0];
          kept_q <= 1'b1;
        end
      end
      BK_TMUL: begin
        v1_q <= v1_w[31:0];
        v2_q <= v2_w[31:0];
      end
      BK_T1: if (div_rsp_i.done) t1_q <= div_rsp_i.quotient[30:0];
      BK_T2: if (div_rsp_i.done) t2_q <= div_rsp_i.quotient[30:0];
      BK_NMUL: begin
        dsq_q <= dsq_w[32:0];
        e1_q  <= e1_w[32:0];
        e2_q  <= e2_w[32:0];
      end
      BK_ACC: begin
        num_q <= num_w;
        den_q <= den_w;
      end
      BK_STAT: begin
        if (div_rsp_i.done) begin
          stat_q <= sat_q16(num_q[34], div_rsp_i.quotient);
          kept_q <= 1'b1;
        end
      end
      BK_WF: begin
        if (densum_q == '0) begin
          wf_q <= '0;
        end else if (div_rsp_i.done) begin
          wf_q <= sat_q16(numsum_q[47], div_rsp_i.quotient);
        end
      end
      default: ;
    endcase
  end

  // running fst sums, saturating
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      numsum_q <= '0;
      densum_q <= '0;
    end else if (state_q == BK_ACC) begin
      if (nsum_w[48] != nsum_w[47]) begin
        numsum_q <= nsum_w[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      end else begin
        numsum_q <= nsum_w[47:0];
      end
      densum_q <= dsum_w[48] ? '1 : dsum_w[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_item_q.site_kept    <= kept_q;
      out_item_q.site_stat    <= stat_q;
      out_item_q.pi_pop1      <= (rec_q.kind == KIND_DXY) ? pi1_q : '0;
      out_item_q.pi_pop2      <= (rec_q.kind == KIND_DXY) ? pi2_q : '0;
      out_item_q.freq_pop1    <= kept_q ? g1_q : '0;
      out_item_q.freq_pop2    <= kept_q ? g2_q : '0;
      out_item_q.weighted_fst <= wf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[test/site_fst_dxy_estimator_unit_test.sv]
// testbench for the per-site fst / dxy estimator: directed and random sites checked against a local predictor
`timescale 1ns / 100ps

module site_fst_dxy_estimator_unit_test;
  import sfde_pkg::*;

  localparam int          MaxHap     = 1024;
  localparam int          WatchLimit = 20000;
  localparam int          SettleWait = 400;
  localparam longint      NumMax     = 64'sd140737488355327;
  localparam longint      NumMin     = -64'sd140737488355328;
  localparam longint unsigned DenMax = 64'd281474976710655;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  site_fst_dxy_estimator_unit #(.MAX_HAPLOTYPES(MaxHap)) u_top (.*);

  // predictor copy of registers and sums
  logic [10:0] hap1, hap2;
  logic [15:0] maf_floor;
  logic        mode_dxy;
  longint          fst_num_sum;
  longint unsigned fst_den_sum;

  in_item_t  site_queue[$];
  out_item_t result_queue[$];
  int send_idle_pct, recv_idle_pct;
  int hold_cycles;
  int quiet_cycles;
  int n_errors;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint q16_ratio(longint num, longint unsigned den);
    logic neg;
    longint unsigned mag, q, r, res;
    neg = num < 0;
    mag = neg ? 64'd0 - longint'(num) : longint'(num);
    q = mag / den;
    r = mag % den;
    if (q >= 65536) res = 64'd1 << 32;
    else res = (q << 16) + ((r << 16) / den);
    if (neg) return (res >= (64'd1 << 31)) ? -64'sd2147483648 : -longint'(res);
    return (res > 64'd2147483647) ? 64'sd2147483647 : longint'(res);
  endfunction

  function automatic out_item_t predict_site(in_item_t it);
    out_item_t o;
    longint unsigned n1, n2, a1, a2, tot, s, mnr, c1, c2, g1, g2, m1, m2, dn, t1, t2, den;
    longint d, num, stat, wf;
    n1 = (hap1 > MaxHap) ? MaxHap : hap1;
    n2 = (hap2 > MaxHap) ? MaxHap : hap2;
    a1 = (it.alt_count_pop1 > n1) ? n1 : it.alt_count_pop1;
    a2 = (it.alt_count_pop2 > n2) ? n2 : it.alt_count_pop2;
    o = '0;
    stat = 0;
    wf = 0;
    if (n1 > 0 && n2 > 0) begin
      tot = n1 + n2;
      s = a1 + a2;
      mnr = (2 * s > tot) ? tot - s : s;
      if (mnr * 65536 >= longint'(maf_floor) * tot) begin
        c1 = it.major_is_alt ? n1 - a1 : a1;
        c2 = it.major_is_alt ? n2 - a2 : a2;
        g1 = (c1 << 16) / n1;
        g2 = (c2 << 16) / n2;
        if (mode_dxy) begin
          m1 = (2 * a1 > n1) ? n1 - a1 : a1;
          m2 = (2 * a2 > n2) ? n2 - a2 : a2;
          dn = c1 * (n2 - c2) + c2 * (n1 - c1);
          o.pi_pop1 = 17'(((2 * m1) << 16) / (n1 + 1));
          o.pi_pop2 = 17'(((2 * m2) << 16) / (n2 + 1));
          stat = (dn << 16) / (n1 * n2);
          o.freq_pop1 = 17'(g1);
          o.freq_pop2 = 17'(g2);
          o.site_kept = 1'b1;
        end else if (n1 >= 2 && n2 >= 2) begin
          d = longint'(g1) - longint'(g2);
          t1 = (g1 * (65536 - g1)) / (n1 - 1);
          t2 = (g2 * (65536 - g2)) / (n2 - 1);
          num = d * d - longint'(t1) - longint'(t2);
          den = g1 * (65536 - g2) + g2 * (65536 - g1);
          fst_num_sum += num;
          if (fst_num_sum > NumMax) fst_num_sum = NumMax;
          if (fst_num_sum < NumMin) fst_num_sum = NumMin;
          fst_den_sum += den;
          if (fst_den_sum > DenMax) fst_den_sum = DenMax;
          if (den > 0) begin
            stat = q16_ratio(num, den);
            o.freq_pop1 = 17'(g1);
            o.freq_pop2 = 17'(g2);
            o.site_kept = 1'b1;
          end
        end
      end
    end
    if (fst_den_sum > 0) wf = q16_ratio(fst_num_sum, fst_den_sum);
    o.site_stat = stat[31:0];
    o.weighted_fst = wf[31:0];
    return o;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (site_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item_i  <= site_queue[0];
        in_valid_i <= 1'b1;
        result_queue.push_back(predict_site(site_queue.pop_front()));
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (result_queue.size() == 0) begin
          $error("result with nothing expected");
          n_errors++;
        end else begin
          out_item_t e;
          e = result_queue.pop_front();
          if (out_item_o.site_kept !== e.site_kept) begin
            $error("site_kept exp %0d got %0d", e.site_kept, out_item_o.site_kept); n_errors++;
          end
          if (out_item_o.site_stat !== e.site_stat) begin
            $error("site_stat exp %0d got %0d", e.site_stat, out_item_o.site_stat); n_errors++;
          end
          if (out_item_o.pi_pop1 !== e.pi_pop1) begin
            $error("pi_pop1 exp %0d got %0d", e.pi_pop1, out_item_o.pi_pop1); n_errors++;
          end
          if (out_item_o.pi_pop2 !== e.pi_pop2) begin
            $error("pi_pop2 exp %0d got %0d", e.pi_pop2, out_item_o.pi_pop2); n_errors++;
          end
          if (out_item_o.freq_pop1 !== e.freq_pop1) begin
            $error("freq_pop1 exp %0d got %0d", e.freq_pop1, out_item_o.freq_pop1); n_errors++;
          end
          if (out_item_o.freq_pop2 !== e.freq_pop2) begin
            $error("freq_pop2 exp %0d got %0d", e.freq_pop2, out_item_o.freq_pop2); n_errors++;
          end
          if (out_item_o.weighted_fst !== e.weighted_fst) begin
            $error("weighted_fst exp %0d got %0d", e.weighted_fst, out_item_o.weighted_fst);
            n_errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (site_queue.size() == 0 && result_queue.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("site_fst_dxy_estimator_unit_test: errors");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_index_e idx, logic [15:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_POP1_HAP: hap1 = val[10:0];
      CFG_POP2_HAP: hap2 = val[10:0];
      CFG_MIN_MAF:  maf_floor = val;
      default:      mode_dxy = val[0];
    endcase
  endtask

  task automatic wait_drained();
    while (site_queue.size() > 0 || result_queue.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic add_site(int a1, int a2, bit maj);
    in_item_t it;
    it.alt_count_pop1 = 11'(a1);
    it.alt_count_pop2 = 11'(a2);
    it.major_is_alt = maj;
    site_queue.push_back(it);
  endtask

  // mostly counts within range, now and then any 11-bit value
  task automatic add_random_sites(int cnt);
    int n1, n2;
    n1 = (hap1 > MaxHap) ? MaxHap : hap1;
    n2 = (hap2 > MaxHap) ? MaxHap : hap2;
    repeat (cnt) begin
      if ($urandom_range(9) == 0) begin
        add_site($urandom_range(2047), $urandom_range(2047), 1'($urandom));
      end else begin
        add_site($urandom_range(n1), $urandom_range(n2), 1'($urandom));
      end
    end
  endtask

  task automatic set_pops(int p1, int p2, int maf, bit mode);
    write_reg(CFG_POP1_HAP, 16'(p1));
    write_reg(CFG_POP2_HAP, 16'(p2));
    write_reg(CFG_MIN_MAF, 16'(maf));
    write_reg(CFG_DXY_MODE, 16'(mode));
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_POP1_HAP;
    cfg_data_i = '0;
    hap1 = 2; hap2 = 2; maf_floor = 0; mode_dxy = 0;
    fst_num_sum = 0; fst_den_sum = 0;
    send_idle_pct = 36; recv_idle_pct = 61;
    hold_cycles = 0;
    n_errors = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: fst with two haplotypes each, then extremes and overflow
    add_site(0, 0, 0); add_site(1, 1, 0); add_site(2, 0, 1); add_site(0, 2, 0);
    add_site(2047, 2047, 1); add_site(1, 2, 0);
    wait_drained();
    set_pops(1024, 1024, 32768, 0);
    add_site(0, 1024, 0); add_site(1024, 0, 1); add_site(512, 512, 0); add_site(1, 0, 0);
    add_site(2047, 5, 1); add_site(700, 300, 0);
    wait_drained();
    // oversized count, empty population, single haplotype
    set_pops(2047, 1, 0, 0);
    add_site(3, 1, 0); add_site(1000, 0, 1);
    wait_drained();
    write_reg(CFG_POP1_HAP, 16'd0);
    add_site(0, 1, 0);
    wait_drained();
    set_pops(1, 1024, 65535, 1);
    add_site(1, 512, 0); add_site(0, 1024, 1); add_site(1, 1, 1);
    wait_drained();
    set_pops(1024, 3, 0, 1);
    add_site(1024, 2, 0); add_site(511, 1, 1); add_site(2047, 2047, 0);
    wait_drained();

    // random phases with changing settings and idling patterns
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin send_idle_pct = 61; recv_idle_pct = 36; end
      if (ph == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
      set_pops($urandom_range(9) < 7 ? $urandom_range(2, 40) : $urandom_range(2, 2047),
               $urandom_range(9) < 7 ? $urandom_range(2, 40) : $urandom_range(2, 2047),
               $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(8000),
               1'(ph % 2));
      if (ph == 7) hold_cycles = 3000;
      add_random_sites(53);
      wait_drained();
    end

    if (n_errors == 0) $display("site_fst_dxy_estimator_unit_test: clean");
    else $display("site_fst_dxy_estimator_unit_test: errors");
    $finish;
  end

endmodule

[sim.f]
src/sfde_pkg.sv
src/sfde_front.sv
src/sfde_queue.sv
src/sfde_divider.sv
src/sfde_back.sv
src/site_fst_dxy_estimator_unit.sv
test/site_fst_dxy_estimator_unit_test.sv
